[hdl/iirl_pkg.sv]
// ============================================================================
// iirl_pkg
// Shared widths, operation and status codes, and the result type of the
// indexed insert/remove list.
// ============================================================================
package iirl_pkg;

    localparam int W_KIND  = 2;
    localparam int W_POS   = 5;
    localparam int W_WORD  = 32;
    localparam int W_STAT  = 2;
    localparam int W_COUNT = 5;

    localparam logic [W_KIND-1:0] OP_GET    = 2'd0;
    localparam logic [W_KIND-1:0] OP_PUT    = 2'd1;
    localparam logic [W_KIND-1:0] OP_INSERT = 2'd2;
    localparam logic [W_KIND-1:0] OP_REMOVE = 2'd3;

    localparam logic [W_STAT-1:0] ST_OK    = 2'd0;
    localparam logic [W_STAT-1:0] ST_RANGE = 2'd1;
    localparam logic [W_STAT-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [W_STAT-1:0]  status;
        logic [W_POS-1:0]   position_out;
        logic [W_WORD-1:0]  read_word;
        logic [W_WORD-1:0]  removed_word;
        logic [W_COUNT-1:0] entry_count;
    } t_result;

endpackage

[hdl/iirl_req_if.sv]
// ============================================================================
// iirl_req_if
// Request channel: valid/ready handshake carrying one list operation.
// ============================================================================
interface iirl_req_if;

    logic                         valid;
    logic                         ready;
    logic [iirl_pkg::W_KIND-1:0]  kind;
    logic [iirl_pkg::W_POS-1:0]   position;
    logic [iirl_pkg::W_WORD-1:0]  word_in;

    modport source (output valid, kind, position, word_in, input ready);
    modport sink   (input valid, kind, position, word_in, output ready);

endinterface

[hdl/iirl_rsp_if.sv]
// ============================================================================
// iirl_rsp_if
// Response channel: valid/ready handshake carrying one operation result.
// ============================================================================
interface iirl_rsp_if;

    logic                          valid;
    logic                          ready;
    logic [iirl_pkg::W_STAT-1:0]   status;
    logic [iirl_pkg::W_POS-1:0]    position_out;
    logic [iirl_pkg::W_WORD-1:0]   read_word;
    logic [iirl_pkg::W_WORD-1:0]   removed_word;
    logic [iirl_pkg::W_COUNT-1:0]  entry_count;

    modport source (output valid, status, position_out, read_word, removed_word,
                    entry_count, input ready);
    modport sink   (input valid, status, position_out, read_word, removed_word,
                    entry_count, output ready);

endinterface

[hdl/iirl_ram.sv]
// ============================================================================
// iirl_ram
// Generic simple dual-port RAM with one write port and one registered read.
// ============================================================================
module iirl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/iirl_ctl.sv]
// ============================================================================
// iirl_ctl
// Operation sequencer: range checks, one shared index stepper that walks the
// shift loops, and read/write control of the entry RAM.
// ============================================================================
module iirl_ctl #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [iirl_pkg::W_KIND-1:0]   i_kind,
    input  logic [iirl_pkg::W_POS-1:0]    i_position,
    input  logic [iirl_pkg::W_WORD-1:0]   i_word_in,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output iirl_pkg::t_result             o_res,
    output logic                          o_we,
    output logic [AW-1:0]                 o_waddr,
    output logic [WORD_BITS-1:0]          o_wdata,
    output logic [AW-1:0]                 o_raddr,
    input  logic [WORD_BITS-1:0]          i_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = iirl_pkg::W_POS;
    localparam int MW = (CW > PW) ? CW : PW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GET  = 3'd1;
    localparam logic [2:0] S_RMRD = 3'd2;
    localparam logic [2:0] S_SHRD = 3'd3;
    localparam logic [2:0] S_SHWR = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]                    r_state, n_state;
    logic [iirl_pkg::W_KIND-1:0]   r_kind, n_kind;
    logic [AW-1:0]                 r_pos, n_pos;
    logic [PW-1:0]                 r_pos_out, n_pos_out;
    logic [WORD_BITS-1:0]          r_word, n_word;
    logic [iirl_pkg::W_STAT-1:0]   r_status, n_status;
    logic [WORD_BITS-1:0]          r_rd, n_rd;
    logic [WORD_BITS-1:0]          r_rm, n_rm;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_idx, n_idx;
    logic [CW-1:0]                 r_lim, n_lim;

    logic [MW-1:0]                 pos_ext;
    logic [MW-1:0]                 cnt_ext;
    logic                          pos_lt;
    logic                          pos_eq;
    logic                          full;
    logic [iirl_pkg::W_STAT-1:0]   chk_status;
    logic [CW-1:0]                 step;

    assign pos_ext = MW'(i_position);
    assign cnt_ext = MW'(r_count);
    assign pos_lt  = pos_ext < cnt_ext;
    assign pos_eq  = pos_ext == cnt_ext;
    assign full    = r_count == CW'(CAPACITY);

    // The single stepping unit: down for insert, up for remove.
    assign step = r_idx + ((r_kind == iirl_pkg::OP_INSERT) ? {CW{1'b1}} : CW'(1));

    always_comb begin
        chk_status = iirl_pkg::ST_OK;
        unique case (i_kind)
            iirl_pkg::OP_GET: begin
                if (!pos_lt) chk_status = iirl_pkg::ST_RANGE;
            end
            iirl_pkg::OP_PUT: begin
                if (!pos_lt && !pos_eq) chk_status = iirl_pkg::ST_RANGE;
                else if (pos_eq && full) chk_status = iirl_pkg::ST_FULL;
            end
            iirl_pkg::OP_INSERT: begin
                if (!pos_lt && !pos_eq) chk_status = iirl_pkg::ST_RANGE;
                else if (full) chk_status = iirl_pkg::ST_FULL;
            end
            iirl_pkg::OP_REMOVE: begin
                if (!pos_lt) chk_status = iirl_pkg::ST_RANGE;
            end
            default: chk_status = iirl_pkg::ST_RANGE;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_pos     = r_pos;
        n_pos_out = r_pos_out;
        n_word    = r_word;
        n_status  = r_status;
        n_rd      = r_rd;
        n_rm      = r_rm;
        n_count   = r_count;
        n_idx     = r_idx;
        n_lim     = r_lim;
        o_we      = 1'b0;
        o_waddr   = r_pos;
        o_wdata   = r_word;
        o_raddr   = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind    = i_kind;
                    n_pos     = AW'(i_position);
                    n_word    = WORD_BITS'(i_word_in);
                    n_status  = chk_status;
                    n_pos_out = (chk_status == iirl_pkg::ST_OK) ? i_position : '0;
                    n_rd      = '0;
                    n_rm      = '0;
                    if (chk_status != iirl_pkg::ST_OK) begin
                        n_state = S_DONE;
                    end else begin
                        unique case (i_kind)
                            iirl_pkg::OP_GET: begin
                                o_raddr = AW'(i_position);
                                n_state = S_GET;
                            end
                            iirl_pkg::OP_PUT: begin
                                o_we    = 1'b1;
                                o_waddr = AW'(i_position);
                                o_wdata = WORD_BITS'(i_word_in);
                                if (pos_eq) n_count = r_count + CW'(1);
                                n_state = S_DONE;
                            end
                            iirl_pkg::OP_INSERT: begin
                                if (pos_eq) begin
                                    o_we    = 1'b1;
                                    o_waddr = AW'(i_position);
                                    o_wdata = WORD_BITS'(i_word_in);
                                    n_count = r_count + CW'(1);
                                    n_state = S_DONE;
                                end else begin
                                    n_idx   = r_count;
                                    n_lim   = CW'(i_position);
                                    n_state = S_SHRD;
                                end
                            end
                            iirl_pkg::OP_REMOVE: begin
                                o_raddr = AW'(i_position);
                                n_idx   = CW'(i_position);
                                n_lim   = r_count - CW'(1);
                                n_state = S_RMRD;
                            end
                            default: n_state = S_DONE;
                        endcase
                    end
                end
            end
            S_GET: begin
                n_rd    = i_rdata;
                n_state = S_DONE;
            end
            S_RMRD: begin
                n_rm = i_rdata;
                if (r_idx != r_lim) begin
                    n_state = S_SHRD;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_SHRD: begin
                o_raddr = step[AW-1:0];
                n_state = S_SHWR;
            end
            S_SHWR: begin
                o_we    = 1'b1;
                o_waddr = r_idx[AW-1:0];
                o_wdata = i_rdata;
                n_idx   = step;
                if (step != r_lim) begin
                    n_state = S_SHRD;
                end else if (r_kind == iirl_pkg::OP_INSERT) begin
                    n_state = S_FIN;
                end else begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end
            end
            S_FIN: begin
                o_we    = 1'b1;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_kind    <= n_kind;
        r_pos     <= n_pos;
        r_pos_out <= n_pos_out;
        r_word    <= n_word;
        r_status  <= n_status;
        r_rd      <= n_rd;
        r_rm      <= n_rm;
        r_idx     <= n_idx;
        r_lim     <= n_lim;
    end

    assign o_ready     = r_state == S_IDLE;
    assign o_res_valid = r_state == S_DONE;

    assign o_res.status       = r_status;
    assign o_res.position_out = r_pos_out;
    assign o_res.read_word    = iirl_pkg::W_WORD'(r_rd);
    assign o_res.removed_word = iirl_pkg::W_WORD'(r_rm);
    assign o_res.entry_count  = iirl_pkg::W_COUNT'(r_count);

endmodule

[hdl/indexed_insert_remove_list.sv]
// ============================================================================
// indexed_insert_remove_list
// Bounded ordered list of data words with get, put/append, insert and remove
// at an index, stored in a RAM and shifted one entry at a time.
// ============================================================================
//  Channel  Dir  Handshake     Payload
//  i_req    in   valid/ready   kind, position, word_in
//  o_rsp    out  valid/ready   status, position_out, read_word, removed_word,
//                              entry_count
//
//  Insert and remove shift entries one at a time, since the entry RAM
//  moves one word per read/write pair.
//  Reset clears the entry count; entry contents need no clearing.
//  A stalled response sits in the output register and the next request is
//  accepted meanwhile; only its own finish waits for that register.
// ============================================================================
module indexed_insert_remove_list #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iirl_req_if.sink   i_req,
    iirl_rsp_if.source o_rsp
);

    localparam int AW = $clog2(CAPACITY);

    logic                  res_valid;
    logic                  res_ready;
    iirl_pkg::t_result     res;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;

    logic                  r_out_valid;
    iirl_pkg::t_result     r_out;

    iirl_ctl #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_req.valid),
        .o_ready     (i_req.ready),
        .i_kind      (i_req.kind),
        .i_position  (i_req.position),
        .i_word_in   (i_req.word_in),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata)
    );

    iirl_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.position_out = r_out.position_out;
    assign o_rsp.read_word    = r_out.read_word;
    assign o_rsp.removed_word = r_out.removed_word;
    assign o_rsp.entry_count  = r_out.entry_count;

endmodule

[hdl/iirl_checker.sv]
// ============================================================================
// iirl_checker
// Port-level checks on the response channel of the list, bound to the top.
// ============================================================================
module iirl_checker #(
    parameter int CAPACITY = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [iirl_pkg::W_STAT-1:0]   i_status,
    input logic [iirl_pkg::W_POS-1:0]    i_position_out,
    input logic [iirl_pkg::W_WORD-1:0]   i_read_word,
    input logic [iirl_pkg::W_WORD-1:0]   i_removed_word,
    input logic [iirl_pkg::W_COUNT-1:0]  i_entry_count
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_entry_count))
        else $error("response changed while stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (32'(i_entry_count) <= 32'(CAPACITY)))
        else $error("entry count above capacity");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status != iirl_pkg::ST_OK) |->
            (i_position_out == '0) && (i_read_word == '0) && (i_removed_word == '0))
        else $error("error response carries data");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_status == iirl_pkg::ST_OK || i_status == iirl_pkg::ST_RANGE ||
                     i_status == iirl_pkg::ST_FULL) &&
                    ((i_read_word == '0) || (i_removed_word == '0)))
        else $error("bad status or both data words set");

endmodule

bind indexed_insert_remove_list iirl_checker #(
    .CAPACITY (CAPACITY)
) u_iirl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_rsp.valid),
    .i_ready        (o_rsp.ready),
    .i_status       (o_rsp.status),
    .i_position_out (o_rsp.position_out),
    .i_read_word    (o_rsp.read_word),
    .i_removed_word (o_rsp.removed_word),
    .i_entry_count  (o_rsp.entry_count)
);

[tb/tb_indexed_insert_remove_list.sv]
// ============================================================================
// tb_indexed_insert_remove_list
// Self-checking testbench for the bounded indexed insert/remove list.
// A queue of list operations, directed corner cases followed by random
// sequences that grow, shrink and churn the list, feeds a clocked driver.
// A clocked monitor runs each accepted operation through a local list model
// and compares every response field against the oldest predicted result.
// Both handshake sides pause at random, and one long response hold-off
// backs the block up until it stalls its request channel.
// ============================================================================
module tb_indexed_insert_remove_list;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_WAIT  = 60;

    typedef struct {
        logic [iirl_pkg::W_KIND-1:0] kind;
        logic [iirl_pkg::W_POS-1:0]  position;
        logic [iirl_pkg::W_WORD-1:0] word_in;
        int                          gap;
    } t_list_op;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    iirl_req_if req_bus ();
    iirl_rsp_if rsp_bus ();

    indexed_insert_remove_list u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    t_list_op                    queued_ops[$];
    iirl_pkg::t_result           predicted_results[$];
    logic [iirl_pkg::W_WORD-1:0] stored_words [CAPACITY];
    int                          stored_count = 0;
    int                          plan_count   = 0;

    logic req_fired = 1'b0;
    logic rsp_fired = 1'b0;
    logic rsp_hold  = 1'b0;
    int   gap_left  = 0;
    int   rsp_wait  = 0;
    int   cycles    = 0;
    int   failures  = 0;
    int   checked   = 0;
    int   peak_count = 0;
    int   kind_seen [4];
    int   status_seen [3];

    function automatic logic [iirl_pkg::W_STAT-1:0] list_status(
        logic [iirl_pkg::W_KIND-1:0] kind, logic [iirl_pkg::W_POS-1:0] pos, int count);
        case (kind)
            iirl_pkg::OP_GET, iirl_pkg::OP_REMOVE: begin
                return (pos >= count) ? iirl_pkg::ST_RANGE : iirl_pkg::ST_OK;
            end
            iirl_pkg::OP_PUT: begin
                if (pos > count) return iirl_pkg::ST_RANGE;
                if (pos == count && count >= CAPACITY) return iirl_pkg::ST_FULL;
                return iirl_pkg::ST_OK;
            end
            default: begin
                if (pos > count) return iirl_pkg::ST_RANGE;
                if (count >= CAPACITY) return iirl_pkg::ST_FULL;
                return iirl_pkg::ST_OK;
            end
        endcase
    endfunction

    function automatic int count_after(logic [iirl_pkg::W_KIND-1:0] kind,
                                       logic [iirl_pkg::W_POS-1:0] pos, int count);
        if (list_status(kind, pos, count) != iirl_pkg::ST_OK) return count;
        case (kind)
            iirl_pkg::OP_INSERT: return count + 1;
            iirl_pkg::OP_REMOVE: return count - 1;
            iirl_pkg::OP_PUT:    return (pos == count) ? count + 1 : count;
            default:             return count;
        endcase
    endfunction

    function automatic iirl_pkg::t_result apply_list_op(
        logic [iirl_pkg::W_KIND-1:0] kind, logic [iirl_pkg::W_POS-1:0] pos,
        logic [iirl_pkg::W_WORD-1:0] word);
        iirl_pkg::t_result           res;
        logic [iirl_pkg::W_STAT-1:0] st;
        int                          next_count;
        int                          n;
        st         = list_status(kind, pos, stored_count);
        next_count = count_after(kind, pos, stored_count);
        res        = '0;
        res.status = st;
        if (st == iirl_pkg::ST_OK) begin
            res.position_out = pos;
            case (kind)
                iirl_pkg::OP_GET: begin
                    res.read_word = stored_words[pos];
                end
                iirl_pkg::OP_PUT: begin
                    stored_words[pos] = word;
                end
                iirl_pkg::OP_INSERT: begin
                    for (n = stored_count; n > pos; n--) stored_words[n] = stored_words[n-1];
                    stored_words[pos] = word;
                end
                default: begin
                    res.removed_word = stored_words[pos];
                    for (n = pos; n + 1 < stored_count; n++) stored_words[n] = stored_words[n+1];
                end
            endcase
        end
        stored_count    = next_count;
        res.entry_count = next_count[iirl_pkg::W_COUNT-1:0];
        return res;
    endfunction

    task automatic add_op(logic [iirl_pkg::W_KIND-1:0] kind, int pos,
                          logic [iirl_pkg::W_WORD-1:0] word, int gap);
        t_list_op op;
        op.kind     = kind;
        op.position = pos[iirl_pkg::W_POS-1:0];
        op.word_in  = word;
        op.gap      = gap;
        queued_ops.push_back(op);
        plan_count = count_after(op.kind, op.position, plan_count);
    endtask

    task automatic plan_directed();
        int k;
        add_op(iirl_pkg::OP_GET, 0, 32'h0, 0);
        add_op(iirl_pkg::OP_REMOVE, 0, 32'h0, 1);
        add_op(iirl_pkg::OP_PUT, 1, 32'hFFFF_FFFF, 0);
        add_op(iirl_pkg::OP_INSERT, 1, 32'hFFFF_FFFF, 2);
        add_op(iirl_pkg::OP_PUT, 0, 32'h0000_0000, 0);
        add_op(iirl_pkg::OP_PUT, 0, 32'hFFFF_FFFF, 0);
        add_op(iirl_pkg::OP_INSERT, 0, 32'hA5A5_5A5A, 0);
        add_op(iirl_pkg::OP_INSERT, 2, 32'h0000_0001, 3);
        add_op(iirl_pkg::OP_GET, 0, 32'h0, 0);
        add_op(iirl_pkg::OP_GET, 2, 32'h0, 0);
        add_op(iirl_pkg::OP_GET, 3, 32'h0, 0);
        for (k = 0; k < 13; k++) begin
            add_op((k % 2) ? iirl_pkg::OP_PUT : iirl_pkg::OP_INSERT,
                   (k % 2) ? plan_count : $urandom_range(0, plan_count), $urandom, 0);
        end
        add_op(iirl_pkg::OP_PUT, 16, 32'h1234_5678, 0);
        add_op(iirl_pkg::OP_INSERT, 16, 32'h1234_5678, 0);
        add_op(iirl_pkg::OP_INSERT, 5, 32'h1234_5678, 0);
        add_op(iirl_pkg::OP_PUT, 15, 32'h8000_0000, 0);
        add_op(iirl_pkg::OP_GET, 16, 32'h0, 0);
        add_op(iirl_pkg::OP_GET, 15, 32'h0, 0);
        add_op(iirl_pkg::OP_REMOVE, 16, 32'h0, 0);
        add_op(iirl_pkg::OP_REMOVE, 15, 32'h0, 0);
        add_op(iirl_pkg::OP_REMOVE, 0, 32'h0, 0);
    endtask

    task automatic plan_random(int total);
        int                          k;
        int                          mode;
        int                          roll;
        int                          pos;
        logic                        calm;
        logic [iirl_pkg::W_KIND-1:0] kind;
        logic [iirl_pkg::W_WORD-1:0] word;
        mode = 0;
        calm = 1'b0;
        for (k = 0; k < total; k++) begin
            if (k % 40 == 0) begin
                mode = $urandom_range(0, 2);
                calm = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            case (mode)
                0: kind = (roll < 45) ? iirl_pkg::OP_INSERT : (roll < 75) ? iirl_pkg::OP_PUT :
                          (roll < 88) ? iirl_pkg::OP_GET : iirl_pkg::OP_REMOVE;
                1: kind = (roll < 50) ? iirl_pkg::OP_REMOVE : (roll < 75) ? iirl_pkg::OP_GET :
                          (roll < 88) ? iirl_pkg::OP_PUT : iirl_pkg::OP_INSERT;
                default: kind = roll[1:0];
            endcase
            if ($urandom_range(0, 9) == 0) begin
                pos = $urandom_range(0, 16);
            end else if (kind == iirl_pkg::OP_GET || kind == iirl_pkg::OP_REMOVE) begin
                pos = (plan_count > 0) ? $urandom_range(0, plan_count - 1) : 0;
            end else begin
                pos = $urandom_range(0, plan_count);
            end
            roll = $urandom_range(0, 19);
            word = (roll == 0) ? 32'h0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom;
            add_op(kind, pos, word, calm ? 0 : $urandom_range(0, 5));
        end
    endtask

    task automatic compare_field(string name, logic [iirl_pkg::W_WORD-1:0] exp_val,
                                 logic [iirl_pkg::W_WORD-1:0] act_val);
        if (exp_val !== act_val) begin
            failures++;
            $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, name, exp_val, act_val);
        end
    endtask

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    always @(negedge i_clk) begin
        t_list_op op;
        if (!i_rst_n) begin
            req_bus.valid    <= 1'b0;
            req_bus.kind     <= iirl_pkg::OP_GET;
            req_bus.position <= '0;
            req_bus.word_in  <= '0;
        end else if (req_bus.valid && !req_fired) begin
        end else if (gap_left > 0) begin
            req_bus.valid <= 1'b0;
            gap_left--;
        end else if (queued_ops.size() > 0) begin
            op = queued_ops.pop_front();
            req_bus.valid    <= 1'b1;
            req_bus.kind     <= op.kind;
            req_bus.position <= op.position;
            req_bus.word_in  <= op.word_in;
            gap_left = op.gap;
        end else begin
            req_bus.valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_fired) rsp_wait = ((checked / 100) % 4 == 2) ? 0 : $urandom_range(0, 5);
            if (rsp_wait > 0) begin
                rsp_bus.ready <= 1'b0;
                rsp_wait--;
            end else begin
                rsp_bus.ready <= !rsp_hold;
            end
        end
    end

    initial begin
        while (checked < 150) @(posedge i_clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        iirl_pkg::t_result exp_res;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
                     predicted_results.size());
            $display("indexed_insert_remove_list: mismatch");
            $finish;
        end
        if (i_rst_n) begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (predicted_results.size() == 0) begin
                    failures++;
                    $display("%0t ns: unexpected response transaction, status %0d", $time,
                             rsp_bus.status);
                end else begin
                    exp_res = predicted_results.pop_front();
                    compare_field("status", exp_res.status, rsp_bus.status);
                    compare_field("position_out", exp_res.position_out, rsp_bus.position_out);
                    compare_field("read_word", exp_res.read_word, rsp_bus.read_word);
                    compare_field("removed_word", exp_res.removed_word, rsp_bus.removed_word);
                    compare_field("entry_count", exp_res.entry_count, rsp_bus.entry_count);
                    status_seen[exp_res.status]++;
                    checked++;
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                predicted_results.push_back(apply_list_op(req_bus.kind, req_bus.position,
                                                          req_bus.word_in));
                kind_seen[req_bus.kind]++;
                if (stored_count > peak_count) peak_count = stored_count;
            end
        end
        req_fired <= req_bus.valid && req_bus.ready;
        rsp_fired <= rsp_bus.valid && rsp_bus.ready;
    end

    initial begin
        plan_directed();
        plan_random(700);
        while (!i_rst_n) @(posedge i_clk);
        while (queued_ops.size() > 0 || req_bus.valid || gap_left > 0 ||
               predicted_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (predicted_results.size() > 0) begin
            failures += predicted_results.size();
            $display("%0d predicted results never arrived.", predicted_results.size());
        end
        $display("Checked %0d transactions: %0d get, %0d put, %0d insert, %0d remove.",
                 checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        $display("Status ok %0d, out of range %0d, full %0d; peak list length %0d.",
                 status_seen[0], status_seen[1], status_seen[2], peak_count);
        if (failures == 0) begin
            $display("indexed_insert_remove_list: match");
        end else begin
            $display("indexed_insert_remove_list: mismatch");
        end
        $finish;
    end

endmodule
